### hw/rtl/ppsp_pkg.sv
// Shared constants, types and the control program of the wheel speed regulator.
`default_nettype none
package ppsp_pkg;

   // fixed point and field widths
   localparam int FRAC_BITS  = 16;
   localparam int TIME_W     = 16;
   localparam int TP_W       = 17;
   localparam int TGT_W      = 18;
   localparam int NUM_W      = 32;
   localparam int GAIN_W     = 16;
   localparam int LIM_W      = 16;
   localparam int DUTY_W     = 16;
   localparam int SPEED_W    = 32;
   localparam int CNT_W      = 2;
   localparam int DIFF_W     = TIME_W + 2;
   // an unwrapped period can need a 17th bit when the timer length is large
   localparam int DIV_W      = TIME_W + 1;
   localparam int DIVCNT_W   = 5;
   localparam int ERR_W      = SPEED_W + 2;
   localparam int DERIV_W    = ERR_W + 1;
   localparam int MUL_A_W    = DERIV_W + 1;
   localparam int MUL_B_W    = GAIN_W + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int GAIN_SHIFT = 8;
   localparam int TERM_W     = PROD_W - GAIN_SHIFT;
   localparam int ACC_W      = 48;
   localparam int BOUND_W    = LIM_W + FRAC_BITS;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;
   localparam int REQ_DW     = 16;
   localparam int RSP_DW     = 48;

   localparam logic [CNT_W-1:0] CAPTURES_NEEDED = 2'd2;

   // register map, index = paddr[4:2]
   typedef logic [2:0] reg_idx_type;
   localparam reg_idx_type REG_TARGET    = 3'd0;
   localparam reg_idx_type REG_NUMERATOR = 3'd1;
   localparam reg_idx_type REG_PROP_GAIN = 3'd2;
   localparam reg_idx_type REG_INTEG_GAIN = 3'd3;
   localparam reg_idx_type REG_DERIV_GAIN = 3'd4;
   localparam reg_idx_type REG_INTEG_LIM = 3'd5;
   localparam reg_idx_type REG_MAX_DUTY  = 3'd6;
   localparam reg_idx_type REG_TIMER_PER = 3'd7;

   localparam logic [TGT_W-1:0]  RST_TARGET     = 18'd98304;
   localparam logic [NUM_W-1:0]  RST_NUMERATOR  = 32'd358773722;
   localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 16'd256;
   localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = 16'd1280;
   localparam logic [GAIN_W-1:0] RST_DERIV_GAIN = 16'd256;
   localparam logic [LIM_W-1:0]  RST_INTEG_LIM  = 16'd10000;
   localparam logic [DUTY_W-1:0] RST_MAX_DUTY   = 16'd10000;
   localparam logic [TP_W-1:0]   RST_TIMER_PER  = 17'd65000;

   // input kinds
   localparam logic FUNC_CAPTURE = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   // microcode
   typedef enum logic [3:0] {
      DP_WAIT,
      DP_PERIOD,
      DP_DIV,
      DP_SPEED,
      DP_ERR,
      DP_MUL_I,
      DP_ACC_I,
      DP_CLAMP_I,
      DP_MUL_P,
      DP_ACC_P,
      DP_MUL_D,
      DP_ACC_D,
      DP_OUT
   } dp_op_type;

   typedef enum logic [1:0] {
      SC_ALWAYS,
      SC_GO,
      SC_DIV_DONE,
      SC_OUT_FREE
   } seq_cond_type;

   typedef logic [3:0] uaddr_type;

   typedef struct packed {
      dp_op_type    op;
      seq_cond_type cond;
      uaddr_type    target;
   } ucode_type;

   localparam uaddr_type UA_WAIT    = 4'd0;
   localparam uaddr_type UA_PERIOD  = 4'd1;
   localparam uaddr_type UA_DIV     = 4'd2;
   localparam uaddr_type UA_SPEED   = 4'd3;
   localparam uaddr_type UA_ERR     = 4'd4;
   localparam uaddr_type UA_MUL_I   = 4'd5;
   localparam uaddr_type UA_ACC_I   = 4'd6;
   localparam uaddr_type UA_CLAMP_I = 4'd7;
   localparam uaddr_type UA_MUL_P   = 4'd8;
   localparam uaddr_type UA_ACC_P   = 4'd9;
   localparam uaddr_type UA_MUL_D   = 4'd10;
   localparam uaddr_type UA_ACC_D   = 4'd11;
   localparam uaddr_type UA_OUT     = 4'd12;

   // a step holds (and repeats its op) until its condition is met, then jumps
   function automatic ucode_type ucode_rom(input uaddr_type addr);
      case (addr)
         UA_WAIT:    return '{DP_WAIT,    SC_GO,       UA_PERIOD};
         UA_PERIOD:  return '{DP_PERIOD,  SC_ALWAYS,   UA_DIV};
         UA_DIV:     return '{DP_DIV,     SC_DIV_DONE, UA_SPEED};
         UA_SPEED:   return '{DP_SPEED,   SC_ALWAYS,   UA_ERR};
         UA_ERR:     return '{DP_ERR,     SC_ALWAYS,   UA_MUL_I};
         UA_MUL_I:   return '{DP_MUL_I,   SC_ALWAYS,   UA_ACC_I};
         UA_ACC_I:   return '{DP_ACC_I,   SC_ALWAYS,   UA_CLAMP_I};
         UA_CLAMP_I: return '{DP_CLAMP_I, SC_ALWAYS,   UA_MUL_P};
         UA_MUL_P:   return '{DP_MUL_P,   SC_ALWAYS,   UA_ACC_P};
         UA_ACC_P:   return '{DP_ACC_P,   SC_ALWAYS,   UA_MUL_D};
         UA_MUL_D:   return '{DP_MUL_D,   SC_ALWAYS,   UA_ACC_D};
         UA_ACC_D:   return '{DP_ACC_D,   SC_ALWAYS,   UA_OUT};
         UA_OUT:     return '{DP_OUT,     SC_OUT_FREE, UA_WAIT};
         default:    return '{DP_WAIT,    SC_ALWAYS,   UA_WAIT};
      endcase
   endfunction

endpackage
`default_nettype wire

### hw/rtl/pulse_period_speed_pid.sv
// Wheel speed PID regulator: microcoded sequencer, serial divider, shared multiplier.
// Program: a tick word (with two captures held), once accepted, runs 1 period step,
//   32 divider steps and 10 arithmetic steps, the last waiting for a free output.
// Input: capture words one per cycle while the sequencer waits; no word is taken
//   while the program runs its 32-step restoring divider and single shared multiplier.
// Reset (synchronous, active high): registers to their defaults, timestamps,
//   capture count, previous error and integral to zero. No clearing pass.
`default_nettype none
module pulse_period_speed_pid (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request: tdata = capture_time[15:0]; tuser = func
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [ppsp_pkg::REQ_DW-1:0]  req_tdata,
   input  wire logic                         req_tuser,
   // response: tdata = duty[15:0], speed[47:16]
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [ppsp_pkg::RSP_DW-1:0]       rsp_tdata,
   // register port
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [ppsp_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [ppsp_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [ppsp_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                              csr_pready
);
   import ppsp_pkg::*;

   // ---- configuration registers ----
   logic [TGT_W-1:0]  target_ff,     target_in;
   logic [NUM_W-1:0]  numerator_ff,  numerator_in;
   logic [GAIN_W-1:0] prop_gain_ff,  prop_gain_in;
   logic [GAIN_W-1:0] integ_gain_ff, integ_gain_in;
   logic [GAIN_W-1:0] deriv_gain_ff, deriv_gain_in;
   logic [LIM_W-1:0]  integ_lim_ff,  integ_lim_in;
   logic [DUTY_W-1:0] max_duty_ff,   max_duty_in;
   logic [TP_W-1:0]   timer_per_ff,  timer_per_in;

   // ---- sequencer ----
   uaddr_type upc_ff, upc_in;
   ucode_type uword;
   logic      cond_ok;

   // ---- control state ----
   logic [TIME_W-1:0] newest_ff, newest_in;
   logic [TIME_W-1:0] older_ff,  older_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic signed [ERR_W-1:0] prev_err_ff, prev_err_in;
   logic signed [ACC_W-1:0] integral_ff, integral_in;
   logic rsp_valid_ff, rsp_valid_in;

   // ---- datapath scratch ----
   logic              sat_ff,     sat_in;
   logic [DIV_W-1:0]  divisor_ff, divisor_in;
   logic [DIV_W-1:0]  rem_ff,     rem_in;
   logic [NUM_W-1:0]  quot_ff,    quot_in;
   logic [DIVCNT_W-1:0] divcnt_ff, divcnt_in;
   logic [SPEED_W-1:0] speed_ff,  speed_in;
   logic signed [ERR_W-1:0]   err_ff,   err_in;
   logic signed [DERIV_W-1:0] deriv_ff, deriv_in;
   logic signed [PROD_W-1:0]  prod_ff,  prod_in;
   logic signed [ACC_W-1:0]   pid_ff,   pid_in;
   logic [DUTY_W-1:0]  rsp_duty_ff,  rsp_duty_in;
   logic [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;

   // ---- combinational helpers ----
   logic                        csr_wr;
   logic                        req_acc;
   logic                        go;
   logic signed [DIFF_W-1:0]    diff;
   logic signed [DIFF_W-1:0]    period_adj;
   logic [DIV_W:0]              div_shift;
   logic                        div_fit;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [TERM_W-1:0]    term;
   logic signed [ACC_W-1:0]     term_ext;
   logic signed [ACC_W-1:0]     bound;
   logic [ACC_W-FRAC_BITS-1:0]  duty_whole;
   logic [DUTY_W-1:0]           duty_val;
   logic                        out_load;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register read back
   always_comb begin
      case (reg_idx_type'(csr_paddr[CSR_AW-1:2]))
         REG_TARGET:     csr_prdata = CSR_DW'(target_ff);
         REG_NUMERATOR:  csr_prdata = CSR_DW'(numerator_ff);
         REG_PROP_GAIN:  csr_prdata = CSR_DW'(prop_gain_ff);
         REG_INTEG_GAIN: csr_prdata = CSR_DW'(integ_gain_ff);
         REG_DERIV_GAIN: csr_prdata = CSR_DW'(deriv_gain_ff);
         REG_INTEG_LIM:  csr_prdata = CSR_DW'(integ_lim_ff);
         REG_MAX_DUTY:   csr_prdata = CSR_DW'(max_duty_ff);
         REG_TIMER_PER:  csr_prdata = CSR_DW'(timer_per_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // microcode fetch and step condition
   assign uword      = ucode_rom(upc_ff);
   assign req_tready = (uword.op == DP_WAIT);
   assign req_acc    = req_tvalid && req_tready;
   // only a tick with two timestamps held starts the program
   assign go         = req_acc && (req_tuser == FUNC_TICK) && (count_ff == CAPTURES_NEEDED);

   always_comb begin
      case (uword.cond)
         SC_ALWAYS:   cond_ok = 1'b1;
         SC_GO:       cond_ok = go;
         SC_DIV_DONE: cond_ok = (divcnt_ff == '1);
         SC_OUT_FREE: cond_ok = !rsp_valid_ff || rsp_tready;
         default:     cond_ok = 1'b1;
      endcase
   end

   assign upc_in = cond_ok ? uword.target : upc_ff;

   // period between the two newest edges, unwrapped once by the timer length
   assign diff       = $signed({2'b00, newest_ff}) - $signed({2'b00, older_ff});
   assign period_adj = diff[DIFF_W-1] ? diff + $signed({1'b0, timer_per_ff}) : diff;

   // restoring divider step
   assign div_shift = {rem_ff, quot_ff[NUM_W-1]};
   assign div_fit   = (div_shift >= {1'b0, divisor_ff});

   // shared multiplier operands
   always_comb begin
      mul_a = MUL_A_W'(err_ff);
      mul_b = $signed({1'b0, prop_gain_ff});
      case (uword.op)
         DP_MUL_I: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = $signed({1'b0, integ_gain_ff});
         end
         DP_MUL_D: begin
            mul_a = MUL_A_W'(deriv_ff);
            mul_b = $signed({1'b0, deriv_gain_ff});
         end
         default: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = $signed({1'b0, prop_gain_ff});
         end
      endcase
   end

   // arithmetic shift dropping the Q8.8 gain's fraction bits floors towards minus infinity
   assign term     = prod_ff[PROD_W-1:GAIN_SHIFT];
   assign term_ext = ACC_W'(term);
   assign bound    = $signed(ACC_W'({integ_lim_ff, {FRAC_BITS{1'b0}}}));

   // duty clamp
   assign duty_whole = pid_ff[ACC_W-1:FRAC_BITS];
   always_comb begin
      if (pid_ff[ACC_W-1] || (pid_ff == '0)) begin
         duty_val = '0;
      end else if (duty_whole > (ACC_W-FRAC_BITS)'(max_duty_ff)) begin
         duty_val = max_duty_ff;
      end else begin
         duty_val = duty_whole[DUTY_W-1:0];
      end
   end

   assign out_load = (uword.op == DP_OUT) && cond_ok;

   always_comb begin
      target_in     = target_ff;
      numerator_in  = numerator_ff;
      prop_gain_in  = prop_gain_ff;
      integ_gain_in = integ_gain_ff;
      deriv_gain_in = deriv_gain_ff;
      integ_lim_in  = integ_lim_ff;
      max_duty_in   = max_duty_ff;
      timer_per_in  = timer_per_ff;
      newest_in     = newest_ff;
      older_in      = older_ff;
      count_in      = count_ff;
      prev_err_in   = prev_err_ff;
      integral_in   = integral_ff;
      sat_in        = sat_ff;
      divisor_in    = divisor_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      divcnt_in     = divcnt_ff;
      speed_in      = speed_ff;
      err_in        = err_ff;
      deriv_in      = deriv_ff;
      prod_in       = prod_ff;
      pid_in        = pid_ff;
      rsp_duty_in   = rsp_duty_ff;
      rsp_speed_in  = rsp_speed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (csr_wr) begin
         case (reg_idx_type'(csr_paddr[CSR_AW-1:2]))
            REG_TARGET:     target_in     = csr_pwdata[TGT_W-1:0];
            REG_NUMERATOR:  numerator_in  = csr_pwdata[NUM_W-1:0];
            REG_PROP_GAIN:  prop_gain_in  = csr_pwdata[GAIN_W-1:0];
            REG_INTEG_GAIN: integ_gain_in = csr_pwdata[GAIN_W-1:0];
            REG_DERIV_GAIN: deriv_gain_in = csr_pwdata[GAIN_W-1:0];
            REG_INTEG_LIM:  integ_lim_in  = csr_pwdata[LIM_W-1:0];
            REG_MAX_DUTY:   max_duty_in   = csr_pwdata[DUTY_W-1:0];
            REG_TIMER_PER:  timer_per_in  = csr_pwdata[TP_W-1:0];
            default: ;
         endcase
      end

      case (uword.op)
         DP_WAIT: begin
            if (req_acc && (req_tuser == FUNC_CAPTURE)) begin
               older_in  = newest_ff;
               newest_in = req_tdata[TIME_W-1:0];
               if (count_ff != CAPTURES_NEEDED) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         DP_PERIOD: begin
            sat_in     = period_adj[DIFF_W-1] || (period_adj == '0);
            divisor_in = period_adj[DIV_W-1:0];
            rem_in     = '0;
            quot_in    = numerator_ff;
            divcnt_in  = '0;
         end
         DP_DIV: begin
            rem_in    = div_fit ? DIV_W'(div_shift - {1'b0, divisor_ff})
                                : div_shift[DIV_W-1:0];
            quot_in   = {quot_ff[NUM_W-2:0], div_fit};
            divcnt_in = divcnt_ff + 1'b1;
         end
         DP_SPEED: begin
            speed_in = sat_ff ? '1 : quot_ff;
         end
         DP_ERR: begin
            err_in   = $signed(ERR_W'(target_ff)) - $signed(ERR_W'(speed_ff));
            deriv_in = DERIV_W'(err_in) - DERIV_W'(prev_err_ff);
         end
         DP_MUL_I, DP_MUL_P, DP_MUL_D: begin
            prod_in = mul_a * mul_b;
         end
         DP_ACC_I: begin
            integral_in = integral_ff + term_ext;
         end
         DP_CLAMP_I: begin
            if (integral_ff > bound) begin
               integral_in = bound;
            end else if (integral_ff < -bound) begin
               integral_in = -bound;
            end
         end
         DP_ACC_P: begin
            pid_in = integral_ff + term_ext;
         end
         DP_ACC_D: begin
            pid_in      = pid_ff + term_ext;
            prev_err_in = err_ff;
         end
         DP_OUT: begin
            if (out_load) begin
               rsp_duty_in  = duty_val;
               rsp_speed_in = speed_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= RST_TARGET;
         numerator_ff  <= RST_NUMERATOR;
         prop_gain_ff  <= RST_PROP_GAIN;
         integ_gain_ff <= RST_INTEG_GAIN;
         deriv_gain_ff <= RST_DERIV_GAIN;
         integ_lim_ff  <= RST_INTEG_LIM;
         max_duty_ff   <= RST_MAX_DUTY;
         timer_per_ff  <= RST_TIMER_PER;
         upc_ff        <= UA_WAIT;
         newest_ff     <= '0;
         older_ff      <= '0;
         count_ff      <= '0;
         prev_err_ff   <= '0;
         integral_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         target_ff     <= target_in;
         numerator_ff  <= numerator_in;
         prop_gain_ff  <= prop_gain_in;
         integ_gain_ff <= integ_gain_in;
         deriv_gain_ff <= deriv_gain_in;
         integ_lim_ff  <= integ_lim_in;
         max_duty_ff   <= max_duty_in;
         timer_per_ff  <= timer_per_in;
         upc_ff        <= upc_in;
         newest_ff     <= newest_in;
         older_ff      <= older_in;
         count_ff      <= count_in;
         prev_err_ff   <= prev_err_in;
         integral_ff   <= integral_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      // datapath scratch and response payload
      sat_ff       <= sat_in;
      divisor_ff   <= divisor_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      divcnt_ff    <= divcnt_in;
      speed_ff     <= speed_in;
      err_ff       <= err_in;
      deriv_ff     <= deriv_in;
      prod_ff      <= prod_in;
      pid_ff       <= pid_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_speed_ff <= rsp_speed_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_speed_ff, rsp_duty_ff};

   // ---- checks ----
   // integral is within its bound once the clamp step has run
   a_integral_bounded: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == UA_MUL_P) |-> ((integral_ff <= bound) && (integral_ff >= -bound)))
      else $error("integral outside its bound after clamp");

   // speed is only formed straight after the divider finishes
   a_speed_after_div: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == UA_SPEED) |-> ($past(upc_ff) == UA_DIV))
      else $error("speed step not preceded by divider");

   // a freshly loaded duty never exceeds the clamp
   a_duty_clamped: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_duty_ff <= max_duty_ff))
      else $error("duty above max_duty");

endmodule
`default_nettype wire
